@@ rtl/gpe_pkg.sv @@
// Shared constants, register codes and pipeline word types for the gas property evaluator.
package gpe_pkg;

  // Pipeline depths of the iterative units (one quotient or root bit per stage)
  localparam int unsigned QDIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned MUDIV_STEPS = 64;
  localparam int unsigned TDIV_STEPS  = 40;
  localparam int unsigned RHO_STEPS   = 32;
  localparam int unsigned K_STEPS     = 32;
  localparam int unsigned TEMP_W      = 32;

  // Register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_PRESSURE  = 3'd0;
  localparam reg_idx_t REG_GAS_CONST = 3'd1;
  localparam reg_idx_t REG_REF_VISC  = 3'd2;
  localparam reg_idx_t REG_REF_TEMP  = 3'd3;
  localparam reg_idx_t REG_SUTH      = 3'd4;
  localparam reg_idx_t REG_PRANDTL   = 3'd5;

  // Reset values
  localparam logic [23:0] RST_PRESSURE  = 24'd101325;
  localparam logic [31:0] RST_GAS_CONST = 32'd18815484;
  localparam logic [31:0] RST_REF_VISC  = 32'd18471936;
  localparam logic [31:0] RST_REF_TEMP  = 32'd286261248;
  localparam logic [31:0] RST_SUTH      = 32'd115867648;
  localparam logic [15:0] RST_PRANDTL   = 16'd2908;

  // Cell kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_FLUID     = 2'd0;
  localparam kind_t KIND_INTERFACE = 2'd1;
  localparam kind_t KIND_SOLID     = 2'd2;

  typedef struct packed {
    logic [23:0] pressure;
    logic [31:0] gas_const;
    logic [31:0] ref_visc;
    logic [31:0] ref_temp;
    logic [31:0] suth;
    logic [15:0] prandtl;
  } cfg_t;

  // Sideband travelling with each word
  typedef struct packed {
    logic        upd;
    logic        err;
    logic [31:0] temp;
    logic [23:0] cp;
  } side_t;

endpackage

@@ rtl/gpe_cfg_regs.sv @@
// APB configuration registers of the gas property evaluator.
module gpe_cfg_regs import gpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressure  <= RST_PRESSURE;
      cfg_q.gas_const <= RST_GAS_CONST;
      cfg_q.ref_visc  <= RST_REF_VISC;
      cfg_q.ref_temp  <= RST_REF_TEMP;
      cfg_q.suth      <= RST_SUTH;
      cfg_q.prandtl   <= RST_PRANDTL;
    end else if (wr_en) begin
      case (idx)
        REG_PRESSURE:  cfg_q.pressure  <= pwdata[23:0];
        REG_GAS_CONST: cfg_q.gas_const <= pwdata;
        REG_REF_VISC:  cfg_q.ref_visc  <= pwdata;
        REG_REF_TEMP:  cfg_q.ref_temp  <= pwdata;
        REG_SUTH:      cfg_q.suth      <= pwdata;
        REG_PRANDTL:   cfg_q.prandtl   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRESSURE:  prdata = {8'd0, cfg_q.pressure};
      REG_GAS_CONST: prdata = cfg_q.gas_const;
      REG_REF_VISC:  prdata = cfg_q.ref_visc;
      REG_REF_TEMP:  prdata = cfg_q.ref_temp;
      REG_SUTH:      prdata = cfg_q.suth;
      REG_PRANDTL:   prdata = {16'd0, cfg_q.prandtl};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/gpe_visc_pipe.sv @@
// Sutherland dynamic viscosity pipeline: ratio divider, square root, products, final divider.
module gpe_visc_pipe import gpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  input  side_t       side_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic [63:0] mu_o
);

  // ---- T/Tr divider, Q32.32 ----
  logic [QDIV_STEPS:0] qd_v_q;
  side_t               qd_s_q   [0:QDIV_STEPS];
  logic [31:0]         qd_rem_q [0:QDIV_STEPS];
  logic [63:0]         qd_quo_q [0:QDIV_STEPS];
  logic [32:0]         qd_sh    [0:QDIV_STEPS-1];
  logic                qd_ge    [0:QDIV_STEPS-1];
  logic [31:0]         qd_rem_d [0:QDIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < QDIV_STEPS; i++) begin
      qd_sh[i]    = {qd_rem_q[i],
                     (i < TEMP_W) ? qd_s_q[i].temp[5'(TEMP_W - 1 - i)] : 1'b0};
      qd_ge[i]    = qd_sh[i] >= {1'b0, cfg_i.ref_temp};
      qd_rem_d[i] = qd_ge[i] ? 32'(qd_sh[i] - {1'b0, cfg_i.ref_temp}) : qd_sh[i][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    qd_s_q[0]   <= side_i;
    qd_rem_q[0] <= '0;
    qd_quo_q[0] <= '0;
    for (int i = 0; i < QDIV_STEPS; i++) begin
      qd_s_q[i+1]   <= qd_s_q[i];
      qd_rem_q[i+1] <= qd_rem_d[i];
      qd_quo_q[i+1] <= {qd_quo_q[i][62:0], qd_ge[i]};
    end
  end

  // ---- square root, one root bit a stage ----
  logic [SQRT_STEPS:0] sq_v_q;
  side_t               sq_s_q    [0:SQRT_STEPS];
  logic [63:0]         sq_x_q    [0:SQRT_STEPS];
  logic [33:0]         sq_rem_q  [0:SQRT_STEPS];
  logic [31:0]         sq_root_q [0:SQRT_STEPS];
  logic [35:0]         sq_src    [0:SQRT_STEPS-1];
  logic [35:0]         sq_trial  [0:SQRT_STEPS-1];
  logic                sq_ge     [0:SQRT_STEPS-1];
  logic [33:0]         sq_rem_d  [0:SQRT_STEPS-1];

  always_comb begin
    for (int i = 0; i < SQRT_STEPS; i++) begin
      sq_src[i]   = {sq_rem_q[i], sq_x_q[i][6'(63 - 2 * i) -: 2]};
      sq_trial[i] = {2'b00, sq_root_q[i], 2'b01};
      sq_ge[i]    = sq_src[i] >= sq_trial[i];
      sq_rem_d[i] = sq_ge[i] ? 34'(sq_src[i] - sq_trial[i]) : sq_src[i][33:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sq_s_q[0]    <= qd_s_q[QDIV_STEPS];
    sq_x_q[0]    <= qd_quo_q[QDIV_STEPS];
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      sq_s_q[i+1]    <= sq_s_q[i];
      sq_x_q[i+1]    <= sq_x_q[i];
      sq_rem_q[i+1]  <= sq_rem_d[i];
      sq_root_q[i+1] <= {sq_root_q[i][30:0], sq_ge[i]};
    end
  end

  // ---- h = q*r >> 16, saturated; m1 = h*mu0 >> 32; num = m1*(Tr+S) ----
  logic [5:0]  pr_v_q;
  side_t       pr_s_q [0:5];
  logic [63:0] hm_lo_q, hm_hi_q, h_q, mm_lo_q, mm_hi_q, m1_q;
  logic [64:0] nm_lo_q, nm_hi_q;
  logic [95:0] hm_sum, mm_sum;
  logic [32:0] ts_sum, as_sum, d_q [0:1];
  logic [96:0] num_q;

  assign hm_sum = {hm_hi_q, 32'd0} + {32'd0, hm_lo_q};
  assign mm_sum = {mm_hi_q, 32'd0} + {32'd0, mm_lo_q};
  assign as_sum = {1'b0, cfg_i.ref_temp} + {1'b0, cfg_i.suth};
  assign ts_sum = {1'b0, pr_s_q[3].temp} + {1'b0, cfg_i.suth};

  always_ff @(posedge clk_i) begin
    hm_lo_q  <= 64'(sq_x_q[SQRT_STEPS][31:0]) * 64'(sq_root_q[SQRT_STEPS]);
    hm_hi_q  <= 64'(sq_x_q[SQRT_STEPS][63:32]) * 64'(sq_root_q[SQRT_STEPS]);
    pr_s_q[0] <= sq_s_q[SQRT_STEPS];
    h_q      <= (|hm_sum[95:80]) ? '1 : hm_sum[79:16];
    mm_lo_q  <= 64'(h_q[31:0]) * 64'(cfg_i.ref_visc);
    mm_hi_q  <= 64'(h_q[63:32]) * 64'(cfg_i.ref_visc);
    m1_q     <= mm_sum[95:32];
    nm_lo_q  <= 65'(m1_q[31:0]) * 65'(as_sum);
    nm_hi_q  <= 65'(m1_q[63:32]) * 65'(as_sum);
    d_q[0]   <= ts_sum;
    num_q    <= {nm_hi_q, 32'd0} + {32'd0, nm_lo_q};
    d_q[1]   <= d_q[0];
    for (int i = 0; i < 5; i++) pr_s_q[i+1] <= pr_s_q[i];
  end

  // ---- mu = num / (T+S), saturated to 64 bits ----
  logic [MUDIV_STEPS:0] md_v_q;
  side_t                md_s_q   [0:MUDIV_STEPS];
  logic [32:0]          md_rem_q [0:MUDIV_STEPS];
  logic [32:0]          md_d_q   [0:MUDIV_STEPS];
  logic [63:0]          md_low_q [0:MUDIV_STEPS];
  logic [63:0]          md_quo_q [0:MUDIV_STEPS];
  logic                 md_sat_q [0:MUDIV_STEPS];
  logic [33:0]          md_sh    [0:MUDIV_STEPS-1];
  logic                 md_ge    [0:MUDIV_STEPS-1];
  logic [32:0]          md_rem_d [0:MUDIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < MUDIV_STEPS; i++) begin
      md_sh[i]    = {md_rem_q[i], md_low_q[i][63]};
      md_ge[i]    = md_sh[i] >= {1'b0, md_d_q[i]};
      md_rem_d[i] = md_ge[i] ? 33'(md_sh[i] - {1'b0, md_d_q[i]}) : md_sh[i][32:0];
    end
  end

  always_ff @(posedge clk_i) begin
    md_s_q[0]   <= pr_s_q[5];
    md_d_q[0]   <= d_q[1];
    md_sat_q[0] <= num_q[96:64] >= d_q[1];
    md_rem_q[0] <= num_q[96:64];
    md_low_q[0] <= num_q[63:0];
    md_quo_q[0] <= '0;
    for (int i = 0; i < MUDIV_STEPS; i++) begin
      md_s_q[i+1]   <= md_s_q[i];
      md_d_q[i+1]   <= md_d_q[i];
      md_sat_q[i+1] <= md_sat_q[i];
      md_rem_q[i+1] <= md_rem_d[i];
      md_low_q[i+1] <= {md_low_q[i][62:0], 1'b0};
      md_quo_q[i+1] <= {md_quo_q[i][62:0], md_ge[i]};
    end
  end

  // ---- valid bits ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qd_v_q <= '0;
      sq_v_q <= '0;
      pr_v_q <= '0;
      md_v_q <= '0;
    end else begin
      qd_v_q <= {qd_v_q[QDIV_STEPS-1:0], valid_i};
      sq_v_q <= {sq_v_q[SQRT_STEPS-1:0], qd_v_q[QDIV_STEPS]};
      pr_v_q <= {pr_v_q[4:0], sq_v_q[SQRT_STEPS]};
      md_v_q <= {md_v_q[MUDIV_STEPS-1:0], pr_v_q[5]};
    end
  end

  assign valid_o = md_v_q[MUDIV_STEPS];
  assign side_o  = md_s_q[MUDIV_STEPS];
  assign mu_o    = md_sat_q[MUDIV_STEPS] ? '1 : md_quo_q[MUDIV_STEPS];

endmodule

@@ rtl/gpe_trans_pipe.sv @@
// Density, kinematic viscosity and conductivity pipeline with three parallel dividers.
module gpe_trans_pipe import gpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  input  side_t       side_i,
  input  logic [63:0] mu_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic [31:0] rho_o,
  output logic [39:0] nu_o,
  output logic [31:0] k_o
);

  // ---- products ----
  logic [3:0]   pp_v_q;
  side_t        pp_s_q [0:3];
  logic [63:0]  den_q [0:3];
  logic [63:0]  mu1_q;
  logic [55:0]  kl_q, kh_q;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q, ll3_q, hh3_q;
  logic [64:0]  mid_q;
  logic [87:0]  k_sum;
  logic [75:0]  y_q [1:3];
  logic [127:0] x_sum;
  logic [91:0]  x_q;

  assign k_sum = {kh_q, 32'd0} + {32'd0, kl_q};
  assign x_sum = {hh3_q, ll3_q} + {31'd0, mid_q, 32'd0};

  always_ff @(posedge clk_i) begin
    pp_s_q[0] <= side_i;
    den_q[0]  <= 64'(cfg_i.gas_const) * 64'(side_i.temp);
    mu1_q     <= mu_i;
    kl_q      <= 56'(mu_i[31:0]) * 56'(side_i.cp);
    kh_q      <= 56'(mu_i[63:32]) * 56'(side_i.cp);
    ll_q      <= 64'(mu1_q[31:0]) * 64'(den_q[0][31:0]);
    lh_q      <= 64'(mu1_q[31:0]) * 64'(den_q[0][63:32]);
    hl_q      <= 64'(mu1_q[63:32]) * 64'(den_q[0][31:0]);
    hh_q      <= 64'(mu1_q[63:32]) * 64'(den_q[0][63:32]);
    y_q[1]    <= k_sum[87:12];
    mid_q     <= {1'b0, lh_q} + {1'b0, hl_q};
    ll3_q     <= ll_q;
    hh3_q     <= hh_q;
    y_q[2]    <= y_q[1];
    x_q       <= x_sum[127:36];
    y_q[3]    <= y_q[2];
    for (int i = 0; i < 3; i++) begin
      pp_s_q[i+1] <= pp_s_q[i];
      den_q[i+1]  <= den_q[i];
    end
  end

  // ---- dividers: rho and k take the first stages, nu takes them all ----
  logic [TDIV_STEPS:0] td_v_q;
  side_t               td_s_q  [0:TDIV_STEPS];
  logic [63:0]         td_dn_q [0:TDIV_STEPS];
  logic [63:0]         td_rr_q [0:TDIV_STEPS];
  logic [31:0]         td_qr_q [0:TDIV_STEPS];
  logic                td_sr_q [0:TDIV_STEPS];
  logic [23:0]         td_rn_q [0:TDIV_STEPS];
  logic [39:0]         td_ln_q [0:TDIV_STEPS];
  logic [39:0]         td_qn_q [0:TDIV_STEPS];
  logic                td_sn_q [0:TDIV_STEPS];
  logic [15:0]         td_rk_q [0:TDIV_STEPS];
  logic [31:0]         td_lk_q [0:TDIV_STEPS];
  logic [31:0]         td_qk_q [0:TDIV_STEPS];
  logic                td_sk_q [0:TDIV_STEPS];

  logic [64:0] td_rsh [0:TDIV_STEPS-1];
  logic        td_rge [0:TDIV_STEPS-1];
  logic [63:0] td_rr_d [0:TDIV_STEPS-1];
  logic [31:0] td_qr_d [0:TDIV_STEPS-1];
  logic [24:0] td_nsh [0:TDIV_STEPS-1];
  logic        td_nge [0:TDIV_STEPS-1];
  logic [23:0] td_rn_d [0:TDIV_STEPS-1];
  logic [16:0] td_ksh [0:TDIV_STEPS-1];
  logic        td_kge [0:TDIV_STEPS-1];
  logic [15:0] td_rk_d [0:TDIV_STEPS-1];
  logic [31:0] td_lk_d [0:TDIV_STEPS-1];
  logic [31:0] td_qk_d [0:TDIV_STEPS-1];
  logic [63:0] p_sh;

  assign p_sh = {12'd0, cfg_i.pressure, 28'd0};

  always_comb begin
    for (int i = 0; i < TDIV_STEPS; i++) begin
      td_rsh[i]  = {td_rr_q[i], 1'b0};
      td_rge[i]  = (i < RHO_STEPS) && (td_rsh[i] >= {1'b0, td_dn_q[i]});
      if (i < RHO_STEPS) begin
        td_rr_d[i] = td_rge[i] ? 64'(td_rsh[i] - {1'b0, td_dn_q[i]}) : td_rsh[i][63:0];
        td_qr_d[i] = {td_qr_q[i][30:0], td_rge[i]};
      end else begin
        td_rr_d[i] = td_rr_q[i];
        td_qr_d[i] = td_qr_q[i];
      end

      td_nsh[i]  = {td_rn_q[i], td_ln_q[i][39]};
      td_nge[i]  = td_nsh[i] >= {1'b0, cfg_i.pressure};
      td_rn_d[i] = td_nge[i] ? 24'(td_nsh[i] - {1'b0, cfg_i.pressure}) : td_nsh[i][23:0];

      td_ksh[i]  = {td_rk_q[i], td_lk_q[i][31]};
      td_kge[i]  = (i < K_STEPS) && (td_ksh[i] >= {1'b0, cfg_i.prandtl});
      if (i < K_STEPS) begin
        td_rk_d[i] = td_kge[i] ? 16'(td_ksh[i] - {1'b0, cfg_i.prandtl}) : td_ksh[i][15:0];
        td_lk_d[i] = {td_lk_q[i][30:0], 1'b0};
        td_qk_d[i] = {td_qk_q[i][30:0], td_kge[i]};
      end else begin
        td_rk_d[i] = td_rk_q[i];
        td_lk_d[i] = td_lk_q[i];
        td_qk_d[i] = td_qk_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    td_s_q[0]  <= pp_s_q[3];
    td_dn_q[0] <= den_q[3];
    td_sr_q[0] <= p_sh >= den_q[3];
    td_rr_q[0] <= p_sh;
    td_qr_q[0] <= '0;
    td_sn_q[0] <= x_q[91:40] >= {28'd0, cfg_i.pressure};
    td_rn_q[0] <= x_q[63:40];
    td_ln_q[0] <= x_q[39:0];
    td_qn_q[0] <= '0;
    td_sk_q[0] <= y_q[3][75:32] >= {28'd0, cfg_i.prandtl};
    td_rk_q[0] <= y_q[3][47:32];
    td_lk_q[0] <= y_q[3][31:0];
    td_qk_q[0] <= '0;
    for (int i = 0; i < TDIV_STEPS; i++) begin
      td_s_q[i+1]  <= td_s_q[i];
      td_dn_q[i+1] <= td_dn_q[i];
      td_sr_q[i+1] <= td_sr_q[i];
      td_rr_q[i+1] <= td_rr_d[i];
      td_qr_q[i+1] <= td_qr_d[i];
      td_sn_q[i+1] <= td_sn_q[i];
      td_rn_q[i+1] <= td_rn_d[i];
      td_ln_q[i+1] <= {td_ln_q[i][38:0], 1'b0};
      td_qn_q[i+1] <= {td_qn_q[i][38:0], td_nge[i]};
      td_sk_q[i+1] <= td_sk_q[i];
      td_rk_q[i+1] <= td_rk_d[i];
      td_lk_q[i+1] <= td_lk_d[i];
      td_qk_q[i+1] <= td_qk_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q <= '0;
      td_v_q <= '0;
    end else begin
      pp_v_q <= {pp_v_q[2:0], valid_i};
      td_v_q <= {td_v_q[TDIV_STEPS-1:0], pp_v_q[3]};
    end
  end

  assign valid_o = td_v_q[TDIV_STEPS];
  assign side_o  = td_s_q[TDIV_STEPS];
  assign rho_o   = td_sr_q[TDIV_STEPS] ? '1 : td_qr_q[TDIV_STEPS];
  assign nu_o    = td_sn_q[TDIV_STEPS] ? '1 : td_qn_q[TDIV_STEPS];
  assign k_o     = td_sk_q[TDIV_STEPS] ? '1 : td_qk_q[TDIV_STEPS];

endmodule

@@ rtl/gas_property_evaluator_unit.sv @@
// Top level of the gas property evaluator: ideal-gas density, Sutherland viscosity, conductivity.
//
// Use: one grid cell word (temperature_i, heat_capacity_i, cell_kind_i) is taken at each
// rising edge where start is high and busy is low. busy never rises, so a cell may be
// issued every cycle; the sustained rate is one word per clock.
// Every cell gives exactly one result word, shown for one cycle with result_valid_o high.
// Each cell passes through the bit-per-stage dividers (T/Tr 64 stages, (T+S) 64 stages,
// rho/nu/k 40 stages), the 32-stage square root and the multiplier and output registers.
// Results leave in issue order; the receiver cannot hold them off, and nothing stalls.
// Solid interior cells (and the unused kind code) give zeros with updated_o low.
// A zero temperature in a fluid or interface cell gives zeros with error_o high.
// Overflowing results saturate. The APB port holds six 32-bit registers at byte addresses
// 0..20; write them only while no cell is in flight. Reset loads the default air
// properties and empties the pipeline valid bits; no clearing pass is needed.
module gas_property_evaluator_unit import gpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] temperature_i,
  input  logic [23:0] heat_capacity_i,
  input  logic [1:0]  cell_kind_i,
  output logic        result_valid_o,
  output logic [31:0] density_o,
  output logic [39:0] kinematic_viscosity_o,
  output logic [31:0] conductivity_o,
  output logic        updated_o,
  output logic        error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  side_t       in_side, vp_side, tp_side;
  logic        vp_valid, tp_valid;
  logic [63:0] vp_mu;
  logic [31:0] tp_rho, tp_k;
  logic [39:0] tp_nu;
  logic        accept;
  logic        live;

  logic        res_valid_q;
  logic [31:0] density_q, conductivity_q;
  logic [39:0] nu_q;
  logic        updated_q, error_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Kind and zero-temperature flags are settled on entry and ride with the word
  assign in_side.upd  = (cell_kind_i == KIND_FLUID) || (cell_kind_i == KIND_INTERFACE);
  assign in_side.err  = in_side.upd && (temperature_i == 32'd0);
  assign in_side.temp = temperature_i;
  assign in_side.cp   = heat_capacity_i;

  gpe_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Dynamic viscosity
  gpe_visc_pipe u_visc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (accept),
    .side_i  (in_side),
    .valid_o (vp_valid),
    .side_o  (vp_side),
    .mu_o    (vp_mu)
  );

  // Density, kinematic viscosity, conductivity
  gpe_trans_pipe u_trans (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (vp_valid),
    .side_i  (vp_side),
    .mu_i    (vp_mu),
    .valid_o (tp_valid),
    .side_o  (tp_side),
    .rho_o   (tp_rho),
    .nu_o    (tp_nu),
    .k_o     (tp_k)
  );

  // Output register: solid or zero-temperature words get zeroed fields
  assign live = tp_side.upd && !tp_side.err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= tp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    density_q      <= live ? tp_rho : 32'd0;
    nu_q           <= live ? tp_nu : 40'd0;
    conductivity_q <= live ? tp_k : 32'd0;
    updated_q      <= tp_side.upd;
    error_q        <= tp_side.err;
  end

  assign result_valid_o        = res_valid_q;
  assign density_o             = density_q;
  assign kinematic_viscosity_o = nu_q;
  assign conductivity_o        = conductivity_q;
  assign updated_o             = updated_q;
  assign error_o               = error_q;

endmodule
